@@ design/tpi_pkg.sv @@
`default_nettype none

package tpi_pkg;

  localparam int HISTORY_DEPTH = 64;
  localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
  localparam int CNT_W         = SLOT_W + 1;
  localparam int CORDIC_STEPS  = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int BLEND_BITS    = 16;
  localparam int SQRT_TOP      = 30;
  localparam int CW            = 34;
  localparam int KW            = 41;
  localparam int QW            = 40;

  localparam logic [34:0] NEAR_PARALLEL_Q28 = 35'd268301238;
  localparam logic signed [CW-1:0] ONE_Q30  = 34'sd1073741824;

  localparam logic [29:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
    30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
    30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256, 30'd128
  };

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [2:0] ST_INTERP = 3'd0;
  localparam logic [2:0] ST_BEFORE = 3'd1;
  localparam logic [2:0] ST_AFTER  = 3'd2;
  localparam logic [2:0] ST_SINGLE = 3'd3;
  localparam logic [2:0] ST_EMPTY  = 3'd4;

  typedef struct packed {
    logic [63:0] t;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [15:0] rw;
    logic [15:0] rz;
    logic [15:0] ry;
    logic [15:0] rx;
  } entry_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] t;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [15:0] rx;
    logic [15:0] ry;
    logic [15:0] rz;
    logic [15:0] rw;
  } res_t;

  typedef enum logic [18:0] {
    S_IDLE  = 19'd1,
    S_FIRST = 19'd2,
    S_LAST  = 19'd4,
    S_BS    = 19'd8,
    S_BSD   = 19'd16,
    S_E0    = 19'd32,
    S_E1    = 19'd64,
    S_FPREP = 19'd128,
    S_BLEND = 19'd256,
    S_MUL   = 19'd512,
    S_SUM   = 19'd1024,
    S_SQ    = 19'd2048,
    S_SQRT  = 19'd4096,
    S_ATAN  = 19'd8192,
    S_ROT   = 19'd16384,
    S_ANG   = 19'd32768,
    S_DIV   = 19'd65536,
    S_QMUL  = 19'd131072,
    S_QOUT  = 19'd262144
  } state_t;

  typedef enum logic [1:0] {
    RS_DEN,
    RS_A1,
    RS_A2
  } rsel_t;

  function automatic res_t stored_res(input logic [2:0] st, input entry_t e);
    res_t r;
    r.status = st;
    r.t      = e.t;
    r.px     = e.px;
    r.py     = e.py;
    r.pz     = e.pz;
    r.rx     = e.rx;
    r.ry     = e.ry;
    r.rz     = e.rz;
    r.rw     = e.rw;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/timed_pose_interpolator.sv @@
`default_nettype none
// Timed pose interpolator.
// Command channel: start with in_cmd and the in_ payload is a transfer when busy is low.
// A push (in_cmd 0) writes the pose into a 64-entry ring history in the transfer cycle,
// overwriting the oldest entry when full; it gives no result and busy stays low.
// A query (in_cmd 1) raises busy unless the history is empty; it gives exactly one
// result, shown for one cycle with out_valid; the receiver cannot stall, so the result
// is simply taken that cycle. A query on an empty history, a clamped query and one on a
// single entry need no search or blend; an interpolated result takes a binary search of
// at most 7 probes and a linear blend, plus slerp for some rotations. The time is set
// by the single read port of the history memory during the search, the bit-serial blend
// divider, the bit-serial square root, a vectoring pass and three rotation passes of one
// CORDIC unit and two bit-serial weight divisions. One query is in work at a time.
// Reset empties the history; the memory itself is not cleared.
module timed_pose_interpolator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_cmd,
  input  logic [63:0]        in_time_stamp,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [15:0] in_rot_x,
  input  logic signed [15:0] in_rot_y,
  input  logic signed [15:0] in_rot_z,
  input  logic signed [15:0] in_rot_w,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic [63:0]        out_time,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [15:0] out_rot_x,
  output logic signed [15:0] out_rot_y,
  output logic signed [15:0] out_rot_z,
  output logic signed [15:0] out_rot_w
);
  import tpi_pkg::*;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [SLOT_W-1:0] oldest_r, oldest_nxt;
  logic out_valid_r, out_valid_nxt;
  res_t res_r;

  entry_t mem [HISTORY_DEPTH];
  entry_t rdata_r, wdata;
  logic [SLOT_W-1:0] raddr, waddr;
  logic accept, do_push;

  logic [63:0] tgt_r;
  entry_t e0_r, e1_r;
  logic [CNT_W-1:0] lo_r, hi_r, mid, lo_t, lo_cl;
  logic [CNT_W:0] mid_sum;
  logic lo_lt_hi;
  logic [5:0] cnt_r;

  logic [63:0] gap_r, brem_r, gap_c, rem_c, bshift, bsub;
  logic bge, blend_sat;
  logic [16:0] f_r, f_inv;

  logic signed [31:0] p0 [3];
  logic signed [31:0] p1 [3];
  logic signed [15:0] q0 [4];
  logic signed [15:0] q1 [4];
  logic signed [32:0] pdiff [3];
  logic signed [34:0] pround [3];
  logic signed [50:0] pprod_r [3];
  logic signed [31:0] dprod_r [4];
  logic signed [31:0] pos_res_r [3];
  logic signed [34:0] dsum, dabs;
  logic [34:0] dot_r;
  logic signed [16:0] q1n_r [4];
  logic signed [KW-1:0] k1_r, k2_r;

  logic [29:0] cval;
  logic [61:0] sq_v_r, sq_root_r, sq_bit, sq_trial, sq_root_step;
  logic sq_ge;

  logic signed [CW-1:0] cx_r, cy_r, cz_r, cx_step, cy_step, cz_step, xs, ys, at;
  logic [4:0] sh;
  logic signed [CW-1:0] theta_r, den_r, sin1_r, a2_r;
  logic signed [51:0] a1_prod, a2_prod;
  rsel_t rot_sel_r;

  logic div_second_r, dneg_r;
  logic [CW-1:0] drem_r;
  logic [QW-1:0] dnum_r, dquot_r, dq_step;
  logic [CW:0] dtrial;
  logic dge;
  logic signed [KW-1:0] dk;
  logic signed [CW-1:0] dsrc;
  logic [CW-1:0] dmag;
  logic [63:0] dnum_full;

  logic signed [57:0] qprod_r [8];
  logic signed [58:0] qsum [4];
  logic signed [28:0] qv [4];
  logic signed [15:0] qsat [4];

  assign accept  = start && !busy;
  assign do_push = accept && (in_cmd == CMD_PUSH);
  assign busy    = (state_r != S_IDLE);

  // history ring
  assign wdata = '{t: in_time_stamp, px: in_pos_x, py: in_pos_y, pz: in_pos_z,
                   rw: in_rot_w, rz: in_rot_z, ry: in_rot_y, rx: in_rot_x};
  assign waddr = (count_r < CNT_W'(HISTORY_DEPTH)) ? oldest_r + count_r[SLOT_W-1:0]
                                                  : oldest_r;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // binary search
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid      = mid_sum[CNT_W:1];
  assign lo_lt_hi = lo_r < hi_r;
  assign lo_t     = (lo_r >= count_r) ? count_r - 1'b1 : lo_r;
  assign lo_cl    = (lo_t == '0) ? CNT_W'(1) : lo_t;

  always_comb begin
    raddr = oldest_r;
    case (state_r)
      S_FIRST: raddr = oldest_r + SLOT_W'(count_r - 1'b1);
      S_BS: begin
        if (lo_lt_hi) begin
          raddr = oldest_r + mid[SLOT_W-1:0];
        end else begin
          raddr = oldest_r + SLOT_W'(lo_cl - 1'b1);
        end
      end
      S_E0:    raddr = oldest_r + lo_r[SLOT_W-1:0];
      default: raddr = oldest_r;
    endcase
  end

  // blend factor divider
  assign gap_c     = e1_r.t - e0_r.t;
  assign rem_c     = tgt_r - e0_r.t;
  assign blend_sat = (gap_c == '0) || (rem_c >= gap_c);
  assign bshift    = {brem_r[62:0], 1'b0};
  assign bge       = brem_r[63] || (bshift >= gap_r);
  assign bsub      = bshift - gap_r;
  assign f_inv     = 17'h10000 - f_r;

  // translation and dot product
  always_comb begin
    p0[0] = e0_r.px; p0[1] = e0_r.py; p0[2] = e0_r.pz;
    p1[0] = e1_r.px; p1[1] = e1_r.py; p1[2] = e1_r.pz;
    q0[0] = e0_r.rx; q0[1] = e0_r.ry; q0[2] = e0_r.rz; q0[3] = e0_r.rw;
    q1[0] = e1_r.rx; q1[1] = e1_r.ry; q1[2] = e1_r.rz; q1[3] = e1_r.rw;
    for (int k = 0; k < 3; k++) begin
      pdiff[k]  = 33'(p1[k]) - 33'(p0[k]);
      pround[k] = 35'((pprod_r[k] + 51'sd32768) >>> 16);
    end
    dsum = 35'(dprod_r[0]) + 35'(dprod_r[1]) + 35'(dprod_r[2]) + 35'(dprod_r[3]);
    dabs = dsum[34] ? -dsum : dsum;
  end

  // square root
  assign cval         = {dot_r[27:0], 2'b00};
  assign sq_bit       = 62'd1 << {cnt_r, 1'b0};
  assign sq_trial     = sq_root_r + sq_bit;
  assign sq_ge        = sq_v_r >= sq_trial;
  assign sq_root_step = sq_ge ? (sq_root_r >> 1) + sq_bit : sq_root_r >> 1;

  // cordic, vectoring in S_ATAN and rotation in S_ROT
  assign sh = cnt_r[4:0];
  assign xs = cx_r >>> sh;
  assign ys = cy_r >>> sh;
  assign at = CW'(ATAN_Q30[sh]);

  always_comb begin
    if (state_r == S_ATAN) begin
      if (!cy_r[CW-1]) begin
        cx_step = cx_r + ys; cy_step = cy_r - xs; cz_step = cz_r + at;
      end else begin
        cx_step = cx_r - ys; cy_step = cy_r + xs; cz_step = cz_r - at;
      end
    end else begin
      if (!cz_r[CW-1]) begin
        cx_step = cx_r - ys; cy_step = cy_r + xs; cz_step = cz_r - at;
      end else begin
        cx_step = cx_r + ys; cy_step = cy_r - xs; cz_step = cz_r + at;
      end
    end
  end

  assign a1_prod = 52'($signed({1'b0, f_inv})) * 52'(theta_r);
  assign a2_prod = 52'($signed({1'b0, f_r})) * 52'(theta_r);

  // weight divider
  assign dsrc      = (state_r == S_DIV) ? cy_r : sin1_r;
  assign dmag      = dsrc[CW-1] ? CW'(-dsrc) : CW'(dsrc);
  assign dnum_full = {dmag, 30'b0};
  assign dtrial    = {drem_r, dnum_r[QW-1]};
  assign dge       = dtrial >= {1'b0, den_r};
  assign dq_step   = {dquot_r[QW-2:0], dge};
  assign dk        = dneg_r ? -KW'(dq_step) : KW'(dq_step);

  // quaternion blend
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      qsum[k] = 59'(qprod_r[2*k]) + 59'(qprod_r[2*k+1]) + 59'sd536870912;
      qv[k]   = 29'(qsum[k] >>> 30);
      if (qv[k] > 29'sd32767) begin
        qsat[k] = 16'sd32767;
      end else if (qv[k] < -29'sd32768) begin
        qsat[k] = -16'sd32768;
      end else begin
        qsat[k] = 16'(qv[k]);
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    oldest_nxt    = oldest_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_PUSH) begin
            if (count_r < CNT_W'(HISTORY_DEPTH)) begin
              count_nxt = count_r + 1'b1;
            end else begin
              oldest_nxt = oldest_r + 1'b1;
            end
          end else if (count_r == '0) begin
            out_valid_nxt = 1'b1;
          end else begin
            state_nxt = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        if (tgt_r < rdata_r.t) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        if (tgt_r > rdata_r.t || count_r == CNT_W'(1)) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_BS;
        end
      end
      S_BS:    state_nxt = lo_lt_hi ? S_BSD : S_E0;
      S_BSD:   state_nxt = S_BS;
      S_E0:    state_nxt = S_E1;
      S_E1:    state_nxt = S_FPREP;
      S_FPREP: state_nxt = blend_sat ? S_MUL : S_BLEND;
      S_BLEND: begin
        if (cnt_r == 6'(BLEND_BITS - 1)) state_nxt = S_MUL;
      end
      S_MUL:   state_nxt = S_SUM;
      S_SUM:   state_nxt = (dabs <= NEAR_PARALLEL_Q28) ? S_SQ : S_QMUL;
      S_SQ:    state_nxt = S_SQRT;
      S_SQRT: begin
        if (cnt_r == '0) state_nxt = S_ATAN;
      end
      S_ATAN: begin
        if (cnt_r == 6'(CORDIC_STEPS - 1)) state_nxt = S_ROT;
      end
      S_ROT: begin
        if (cnt_r == 6'(CORDIC_STEPS - 1)) begin
          case (rot_sel_r)
            RS_DEN:  state_nxt = (cy_step > 0) ? S_ANG : S_QMUL;
            RS_A1:   state_nxt = S_ROT;
            RS_A2:   state_nxt = S_DIV;
            default: state_nxt = S_QMUL;
          endcase
        end
      end
      S_ANG:   state_nxt = S_ROT;
      S_DIV: begin
        if (cnt_r == 6'(QW - 1) && div_second_r) state_nxt = S_QMUL;
      end
      S_QMUL:  state_nxt = S_QOUT;
      S_QOUT: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      oldest_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      oldest_r    <= oldest_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          tgt_r <= in_time_stamp;
          if (in_cmd == CMD_QUERY && count_r == '0) begin
            res_r        <= '0;
            res_r.status <= ST_EMPTY;
          end
        end
      end
      S_FIRST: begin
        if (tgt_r < rdata_r.t) res_r <= stored_res(ST_BEFORE, rdata_r);
      end
      S_LAST: begin
        if (tgt_r > rdata_r.t) begin
          res_r <= stored_res(ST_AFTER, rdata_r);
        end else if (count_r == CNT_W'(1)) begin
          res_r <= stored_res(ST_SINGLE, rdata_r);
        end
        lo_r <= '0;
        hi_r <= count_r;
      end
      S_BS: begin
        if (!lo_lt_hi) lo_r <= lo_cl;
      end
      S_BSD: begin
        if (rdata_r.t > tgt_r) begin
          hi_r <= mid;
        end else begin
          lo_r <= mid + 1'b1;
        end
      end
      S_E0: e0_r <= rdata_r;
      S_E1: e1_r <= rdata_r;
      S_FPREP: begin
        gap_r  <= gap_c;
        brem_r <= rem_c;
        f_r    <= blend_sat ? 17'h10000 : '0;
        cnt_r  <= '0;
      end
      S_BLEND: begin
        brem_r <= bge ? bsub : bshift;
        f_r    <= {f_r[15:0], bge};
        cnt_r  <= cnt_r + 1'b1;
      end
      S_MUL: begin
        for (int k = 0; k < 3; k++) begin
          pprod_r[k] <= 51'(pdiff[k]) * 51'($signed({1'b0, f_r}));
        end
        for (int k = 0; k < 4; k++) begin
          dprod_r[k] <= 32'(q0[k]) * 32'(q1[k]);
        end
      end
      S_SUM: begin
        dot_r <= dabs;
        for (int k = 0; k < 4; k++) begin
          q1n_r[k] <= dsum[34] ? -17'(q1[k]) : 17'(q1[k]);
        end
        for (int k = 0; k < 3; k++) begin
          pos_res_r[k] <= 32'(35'(p0[k]) + pround[k]);
        end
        k1_r <= KW'({f_inv, 14'b0});
        k2_r <= KW'({f_r, 14'b0});
      end
      S_SQ: begin
        sq_v_r    <= (62'd1 << 60) - 62'(cval) * 62'(cval);
        sq_root_r <= '0;
        cnt_r     <= 6'(SQRT_TOP);
      end
      S_SQRT: begin
        if (sq_ge) sq_v_r <= sq_v_r - sq_trial;
        sq_root_r <= sq_root_step;
        cnt_r     <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          cx_r  <= CW'(cval);
          cy_r  <= CW'(sq_root_step);
          cz_r  <= '0;
          cnt_r <= '0;
        end
      end
      S_ATAN: begin
        cx_r  <= cx_step;
        cy_r  <= cy_step;
        cz_r  <= cz_step;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 6'(CORDIC_STEPS - 1)) begin
          theta_r   <= cz_step;
          cx_r      <= ONE_Q30;
          cy_r      <= '0;
          cnt_r     <= '0;
          rot_sel_r <= RS_DEN;
        end
      end
      S_ROT: begin
        cx_r  <= cx_step;
        cy_r  <= cy_step;
        cz_r  <= cz_step;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 6'(CORDIC_STEPS - 1)) begin
          cnt_r <= '0;
          case (rot_sel_r)
            RS_DEN: den_r <= cy_step;
            RS_A1: begin
              sin1_r    <= cy_step;
              cx_r      <= ONE_Q30;
              cy_r      <= '0;
              cz_r      <= a2_r;
              rot_sel_r <= RS_A2;
            end
            RS_A2: begin
              dneg_r       <= dsrc[CW-1];
              drem_r       <= CW'(dnum_full[63:QW]);
              dnum_r       <= dnum_full[QW-1:0];
              dquot_r      <= '0;
              div_second_r <= 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_ANG: begin
        cz_r      <= CW'(a1_prod >>> 16);
        a2_r      <= CW'(a2_prod >>> 16);
        cx_r      <= ONE_Q30;
        cy_r      <= '0;
        cnt_r     <= '0;
        rot_sel_r <= RS_A1;
      end
      S_DIV: begin
        drem_r  <= dge ? CW'(dtrial - {1'b0, den_r}) : dtrial[CW-1:0];
        dnum_r  <= dnum_r << 1;
        dquot_r <= dq_step;
        cnt_r   <= cnt_r + 1'b1;
        if (cnt_r == 6'(QW - 1)) begin
          cnt_r <= '0;
          if (!div_second_r) begin
            k1_r         <= dk;
            div_second_r <= 1'b1;
            dneg_r       <= dsrc[CW-1];
            drem_r       <= CW'(dnum_full[63:QW]);
            dnum_r       <= dnum_full[QW-1:0];
            dquot_r      <= '0;
          end else begin
            k2_r <= dk;
          end
        end
      end
      S_QMUL: begin
        for (int k = 0; k < 4; k++) begin
          qprod_r[2*k]   <= 58'(q0[k]) * 58'(k1_r);
          qprod_r[2*k+1] <= 58'(q1n_r[k]) * 58'(k2_r);
        end
      end
      S_QOUT: begin
        res_r.status <= ST_INTERP;
        res_r.t      <= tgt_r;
        res_r.px     <= pos_res_r[0];
        res_r.py     <= pos_res_r[1];
        res_r.pz     <= pos_res_r[2];
        res_r.rx     <= qsat[0];
        res_r.ry     <= qsat[1];
        res_r.rz     <= qsat[2];
        res_r.rw     <= qsat[3];
      end
      default: ;
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_status = res_r.status;
  assign out_time   = res_r.t;
  assign out_pos_x  = res_r.px;
  assign out_pos_y  = res_r.py;
  assign out_pos_z  = res_r.pz;
  assign out_rot_x  = res_r.rx;
  assign out_rot_y  = res_r.ry;
  assign out_rot_z  = res_r.rz;
  assign out_rot_w  = res_r.rw;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(HISTORY_DEPTH))
    else $error("history count out of range");

  a_oldest_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r < CNT_W'(HISTORY_DEPTH)) |-> (oldest_r == '0))
    else $error("oldest slot moved before ring filled");

  a_query_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (count_r != '0))
    else $error("query running on empty history");

  a_search_open: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BSD) |-> lo_lt_hi)
    else $error("search probe with empty range");

  a_interp_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.status == ST_INTERP) |-> ($past(state_r) == S_QOUT))
    else $error("interpolated result without blend");

endmodule
`default_nettype wire

@@ tb/tb_timed_pose_interpolator.sv @@
`timescale 1ns / 1ps

module tb_timed_pose_interpolator;
  import tpi_pkg::*;

  typedef struct {
    logic        cmd;
    logic [63:0] ts;
    logic signed [31:0] pos [3];
    logic signed [15:0] rot [4];
  } pose_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_cmd = 1'b0;
  logic [63:0] in_time_stamp = '0;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [15:0] in_rot_x = '0, in_rot_y = '0, in_rot_z = '0, in_rot_w = '0;
  logic out_valid;
  logic [2:0] out_status;
  logic [63:0] out_time;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [15:0] out_rot_x, out_rot_y, out_rot_z, out_rot_w;

  timed_pose_interpolator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_time_stamp(in_time_stamp),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_rot_x(in_rot_x), .in_rot_y(in_rot_y), .in_rot_z(in_rot_z), .in_rot_w(in_rot_w),
    .out_valid(out_valid), .out_status(out_status), .out_time(out_time),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_rot_x(out_rot_x), .out_rot_y(out_rot_y), .out_rot_z(out_rot_z),
    .out_rot_w(out_rot_w)
  );

  always #5 clk = ~clk;

  // history copy kept by the testbench
  logic [63:0] ring_time [HISTORY_DEPTH];
  longint ring_pos [HISTORY_DEPTH][3];
  longint ring_rot [HISTORY_DEPTH][4];
  int ring_head = 0;
  int ring_count = 0;

  res_t pending_poses [$];
  int error_count = 0;
  bit allow_idle = 1'b1;
  logic [63:0] time_cursor;
  logic signed [15:0] last_rot [4];

  localparam longint ATAN_TBL [16] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768
  };

  function automatic int ring_slot(int logical);
    return (ring_head + logical) % HISTORY_DEPTH;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint angle_of(longint y, longint x);
    longint z, nx, ny;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 16; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z = z + ATAN_TBL[i];
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z = z - ATAN_TBL[i];
      end
      x = nx; y = ny;
    end
    return z;
  endfunction

  function automatic longint scaled_sine(longint z);
    longint x, y, nx, ny;
    x = 64'sd1073741824;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z = z - ATAN_TBL[i];
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z = z + ATAN_TBL[i];
      end
      x = nx; y = ny;
    end
    return y;
  endfunction

  function automatic longint blend_of(logic [63:0] t0, logic [63:0] t1, logic [63:0] tgt);
    logic [63:0] gap, r;
    logic carry;
    longint q;
    gap = t1 - t0;
    r = tgt - t0;
    q = 0;
    if (gap == 0 || r >= gap) return 65536;
    for (int i = 0; i < 16; i++) begin
      carry = r[63];
      r = r << 1;
      q = q << 1;
      if (carry || r >= gap) begin
        r = r - gap;
        q = q | 1;
      end
    end
    return q;
  endfunction

  function automatic res_t stored_pose(logic [2:0] st, int s);
    res_t r;
    r.status = st;
    r.t = ring_time[s];
    r.px = ring_pos[s][0]; r.py = ring_pos[s][1]; r.pz = ring_pos[s][2];
    r.rx = ring_rot[s][0]; r.ry = ring_rot[s][1];
    r.rz = ring_rot[s][2]; r.rw = ring_rot[s][3];
    return r;
  endfunction

  function automatic res_t interpolated_pose(int s0, int s1, logic [63:0] tgt);
    res_t r;
    longint f, dot, k1, k2, c, th, den, a1, a2, v;
    longint q1 [4];
    longint p [3];
    longint qo [4];
    longint unsigned sq;
    f = blend_of(ring_time[s0], ring_time[s1], tgt);
    for (int k = 0; k < 3; k++)
      p[k] = ring_pos[s0][k] + (((ring_pos[s1][k] - ring_pos[s0][k]) * f + 32768) >>> 16);
    dot = 0;
    for (int k = 0; k < 4; k++) begin
      q1[k] = ring_rot[s1][k];
      dot = dot + ring_rot[s0][k] * q1[k];
    end
    if (dot < 0) begin
      for (int k = 0; k < 4; k++) q1[k] = -q1[k];
      dot = -dot;
    end
    k1 = (65536 - f) <<< 14;
    k2 = f <<< 14;
    if (dot <= 268301238) begin
      c = dot * 4;
      sq = (64'd1 << 60) - longint'(c * c);
      th = angle_of(longint'(root_floor(sq)), c);
      den = scaled_sine(th);
      if (den > 0) begin
        a1 = ((65536 - f) * th) >>> 16;
        a2 = (f * th) >>> 16;
        k1 = (scaled_sine(a1) * 64'sd1073741824) / den;
        k2 = (scaled_sine(a2) * 64'sd1073741824) / den;
      end
    end
    for (int k = 0; k < 4; k++) begin
      v = (ring_rot[s0][k] * k1 + q1[k] * k2 + (64'sd1 <<< 29)) >>> 30;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      qo[k] = v;
    end
    r.status = ST_INTERP;
    r.t = tgt;
    r.px = p[0]; r.py = p[1]; r.pz = p[2];
    r.rx = qo[0]; r.ry = qo[1]; r.rz = qo[2]; r.rw = qo[3];
    return r;
  endfunction

  task automatic apply_transfer(pose_item_t it);
    int s, lo, hi, mid, first, last;
    res_t r;
    if (it.cmd == CMD_PUSH) begin
      if (ring_count < HISTORY_DEPTH) begin
        s = ring_slot(ring_count);
        ring_count++;
      end else begin
        s = ring_head;
        ring_head = (ring_head + 1) % HISTORY_DEPTH;
      end
      ring_time[s] = it.ts;
      for (int k = 0; k < 3; k++) ring_pos[s][k] = it.pos[k];
      for (int k = 0; k < 4; k++) ring_rot[s][k] = it.rot[k];
      return;
    end
    if (ring_count == 0) begin
      r = '0;
      r.status = ST_EMPTY;
    end else begin
      first = ring_slot(0);
      last = ring_slot(ring_count - 1);
      if (it.ts < ring_time[first]) r = stored_pose(ST_BEFORE, first);
      else if (it.ts > ring_time[last]) r = stored_pose(ST_AFTER, last);
      else if (ring_count <= 1) r = stored_pose(ST_SINGLE, last);
      else begin
        lo = 0;
        hi = ring_count;
        while (lo < hi) begin
          mid = (lo + hi) / 2;
          if (ring_time[ring_slot(mid)] > it.ts) hi = mid;
          else lo = mid + 1;
        end
        if (lo >= ring_count) lo = ring_count - 1;
        if (lo == 0) lo = 1;
        r = interpolated_pose(ring_slot(lo - 1), ring_slot(lo), it.ts);
      end
    end
    pending_poses.push_back(r);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  always @(posedge clk) begin
    res_t w;
    if (rst_n && out_valid) begin
      if (pending_poses.size() == 0) begin
        report_mismatch("unexpected result", out_time, 64'd0);
      end else begin
        w = pending_poses.pop_front();
        if (out_status !== w.status) report_mismatch("status", out_status, w.status);
        if (out_time !== w.t) report_mismatch("time", out_time, w.t);
        if (out_pos_x !== w.px) report_mismatch("pos_x", out_pos_x, w.px);
        if (out_pos_y !== w.py) report_mismatch("pos_y", out_pos_y, w.py);
        if (out_pos_z !== w.pz) report_mismatch("pos_z", out_pos_z, w.pz);
        if (out_rot_x !== w.rx) report_mismatch("rot_x", out_rot_x, w.rx);
        if (out_rot_y !== w.ry) report_mismatch("rot_y", out_rot_y, w.ry);
        if (out_rot_z !== w.rz) report_mismatch("rot_z", out_rot_z, w.rz);
        if (out_rot_w !== w.rw) report_mismatch("rot_w", out_rot_w, w.rw);
      end
    end
  end

  // one transfer on the command port, called at a falling edge
  task automatic send_pose_cmd(pose_item_t it);
    if (allow_idle && $urandom_range(99) < 22) repeat ($urandom_range(1, 6)) @(negedge clk);
    while (busy) @(negedge clk);
    start = 1'b1;
    in_cmd = it.cmd;
    in_time_stamp = it.ts;
    in_pos_x = it.pos[0]; in_pos_y = it.pos[1]; in_pos_z = it.pos[2];
    in_rot_x = it.rot[0]; in_rot_y = it.rot[1]; in_rot_z = it.rot[2]; in_rot_w = it.rot[3];
    @(posedge clk);
    apply_transfer(it);
    @(negedge clk);
    start = 1'b0;
  endtask

  function automatic pose_item_t make_pose(logic cmd, logic [63:0] ts,
      longint x, longint y, longint z, longint qx, longint qy, longint qz, longint qw);
    pose_item_t it;
    it.cmd = cmd;
    it.ts = ts;
    it.pos[0] = x; it.pos[1] = y; it.pos[2] = z;
    it.rot[0] = qx; it.rot[1] = qy; it.rot[2] = qz; it.rot[3] = qw;
    return it;
  endfunction

  task automatic query_at(logic [63:0] ts);
    send_pose_cmd(make_pose(CMD_QUERY, ts, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom, $urandom));
  endtask

  task automatic drain_results();
    while (pending_poses.size() != 0) @(negedge clk);
  endtask

  task automatic test_empty_and_single();
    query_at(64'd0);
    query_at(64'hFFFF_FFFF_FFFF_FFFF);
    send_pose_cmd(make_pose(CMD_PUSH, 64'd100, 32'h7FFF_FFFF, 32'h8000_0000, 0,
                            16'sh4000, 0, 0, 16'sh8000));
    query_at(64'd100);
    query_at(64'd50);
    query_at(64'd200);
  endtask

  task automatic test_interp_corners();
    send_pose_cmd(make_pose(CMD_PUSH, 64'd100, 32'h8000_0000, 32'h7FFF_FFFF, 5,
                            16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
    query_at(64'd100);
    send_pose_cmd(make_pose(CMD_PUSH, 64'd300, 32'h7FFF_FFFF, 32'h8000_0000, -5,
                            -16'sd16384, 0, 0, 0));
    query_at(64'd200);
    query_at(64'd299);
    send_pose_cmd(make_pose(CMD_PUSH, 64'd1000, 1, 2, 3, -16'sd16380, 100, 0, 0));
    query_at(64'd650);
    send_pose_cmd(make_pose(CMD_PUSH, 64'd1000, 0, 0, 0, 0, 0, 16'sh4000, 0));
    query_at(64'd1000);
    send_pose_cmd(make_pose(CMD_PUSH, 64'd500, 9, 9, 9, 0, 16'sh4000, 0, 0));
    query_at(64'd700);
    send_pose_cmd(make_pose(CMD_PUSH, 64'hFFFF_FFFF_FFFF_FFFE, 32'h8000_0000,
                            32'h8000_0000, 32'h7FFF_FFFF, 16'sh8000, 16'sh8000,
                            16'sh8000, 16'sh8000));
    query_at(64'hFFFF_FFFF_FFFF_FFFF);
    query_at(64'h8000_0000_0000_0000);
    drain_results();
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_push();
    pose_item_t it;
    int m;
    m = $urandom_range(99);
    it.cmd = CMD_PUSH;
    if (m < 6) it.ts = {$urandom, $urandom};
    else if (m < 14) it.ts = time_cursor;
    else it.ts = time_cursor + $urandom_range(1, 5000);
    time_cursor = it.ts;
    for (int k = 0; k < 3; k++) it.pos[k] = rand_pos();
    m = $urandom_range(99);
    for (int k = 0; k < 4; k++) begin
      if (m < 35) it.rot[k] = last_rot[k] + $signed(16'($urandom_range(0, 40))) - 16'sd20;
      else if (m < 45) it.rot[k] = -last_rot[k];
      else if (m < 90) it.rot[k] = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
      else it.rot[k] = $urandom;
    end
    last_rot = it.rot;
    send_pose_cmd(it);
  endtask

  task automatic random_query();
    int m;
    m = $urandom_range(99);
    if (m < 8) query_at({$urandom, $urandom});
    else if (m < 16 && ring_count > 0) query_at(ring_time[ring_slot($urandom_range(ring_count - 1))]);
    else if (m < 22) query_at(time_cursor + $urandom_range(1, 3000));
    else query_at(time_cursor - $urandom_range(0, 60000));
  endtask

  task automatic test_random_traffic();
    time_cursor = {$urandom, $urandom} >> 2;
    last_rot = '{16'sh2000, 16'sh2000, 16'sh2000, 16'sh2000};
    for (int n = 0; n < 1380; n++) begin
      allow_idle = !(n >= 400 && n < 600);
      if (n == 700) drain_results();
      if ($urandom_range(1)) random_push();
      else random_query();
    end
    allow_idle = 1'b1;
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    test_empty_and_single();
    test_interp_corners();
    test_random_traffic();
    drain_results();
    repeat (300) @(negedge clk);
    if (error_count == 0 && pending_poses.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
design/tpi_pkg.sv
design/timed_pose_interpolator.sv
tb/tb_timed_pose_interpolator.sv
